// ===== rtl/core/arpp_pkg.sv =====
// ----------------------------------------------------------------------------
// arpp_pkg: shared types and constants of the ARP packet parser
// Counter width, header offsets, status codes and the packet record that
// passes from the capture front end to the checking back end.
// ----------------------------------------------------------------------------
package arpp_pkg;

  localparam int COUNT_BITS = 11;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // Octet offsets within the ARP payload
  localparam count_t OFS_PROTO = COUNT_BITS'(2);
  localparam count_t OFS_HLEN  = COUNT_BITS'(4);
  localparam count_t OFS_PLEN  = COUNT_BITS'(5);
  localparam count_t OFS_SMAC  = COUNT_BITS'(8);
  localparam count_t OFS_SIP   = COUNT_BITS'(14);
  localparam count_t OFS_TMAC  = COUNT_BITS'(18);
  localparam count_t OFS_TIP   = COUNT_BITS'(24);
  localparam count_t OFS_END   = COUNT_BITS'(28);
  localparam count_t HDR_BYTES = OFS_SMAC;

  localparam logic [7:0]  HW_LEN_OK    = 8'd6;
  localparam logic [7:0]  PROTO_LEN_OK = 8'd4;
  localparam logic [15:0] OP_REQUEST   = 16'd1;
  localparam logic [15:0] OP_REPLY     = 16'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SPACES    = 2'd2;
  localparam logic [1:0] ST_OPCODE    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HW_SPACE    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROTO_SPACE = 1'd1;

  localparam logic [15:0] RST_HW_SPACE    = 16'h0001;
  localparam logic [15:0] RST_PROTO_SPACE = 16'h0800;

  // One finished packet as captured by the front end
  typedef struct packed {
    count_t      count;
    logic [15:0] hw_space;
    logic [15:0] proto_space;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } pkt_rec_t;

endpackage

// ===== rtl/core/arp_packet_parser.sv =====
// ----------------------------------------------------------------------------
// arp_packet_parser: ARP payload parser
// Usage:
//   Input side is a queue write port: one payload octet per transaction on
//   data_byte, qualified by carries_byte; last_item ends the packet (it may
//   carry an octet or be an empty end marker). A transaction happens when
//   push is high and full is low.
//   Result side is a queue read port: one result per packet, shown while
//   empty is low and taken when pop is high.
//   Configuration: cfg_write/cfg_index/cfg_data set the accepted hardware
//   (index 0, reset 1) and protocol (index 1, reset 0x0800) address spaces;
//   write only while no packet is in flight; the block leaves this to the user.
//   Throughput: one octet per cycle while full is low; back-to-back packets of
//   one item each still run at one per cycle while full is low. A result is
//   written into the record queue at the end-of-packet transaction and then
//   moves into the output register, where it can be popped.
//   When the receiver stalls the output register holds, the two-entry record
//   queue fills and then full rises; while full is high no input transaction
//   is taken, octets that do not end a packet included.
//   Reset (rst, synchronous) clears the capture state, empties the record
//   queue and the output register and restores the configuration defaults.
// ----------------------------------------------------------------------------
module arp_packet_parser
  import arpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  // octet input
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              data_byte,
  input  logic                    carries_byte,
  input  logic                    last_item,
  // result output
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status,
  output logic [15:0]             hw_space,
  output logic [15:0]             proto_space,
  output logic [7:0]              hw_length,
  output logic [7:0]              proto_length,
  output logic [15:0]             operation,
  output logic [47:0]             sender_mac,
  output logic [31:0]             sender_ip,
  output logic [47:0]             target_mac,
  output logic [31:0]             target_ip
);

  logic     accept;
  logic     rec_push;
  pkt_rec_t rec_in;
  pkt_rec_t rec_out;
  logic     rec_pop;
  logic     q_empty;

  // Every input transaction is taken; the queue only stalls intake when both
  // records are waiting on the back end.
  assign accept = push && !full;

  arpp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .carries_byte (carries_byte),
    .last_item    (last_item),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  arpp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_pop),
    .rd_data (rec_out),
    .q_full  (full),
    .q_empty (q_empty)
  );

  arpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_empty      (q_empty),
    .q_rec        (rec_out),
    .q_pop        (rec_pop),
    .pop          (pop),
    .empty        (empty),
    .status       (status),
    .hw_space     (hw_space),
    .proto_space  (proto_space),
    .hw_length    (hw_length),
    .proto_length (proto_length),
    .operation    (operation),
    .sender_mac   (sender_mac),
    .sender_ip    (sender_ip),
    .target_mac   (target_mac),
    .target_ip    (target_ip)
  );

endmodule

// ===== rtl/core/arpp_front.sv =====
// ----------------------------------------------------------------------------
// arpp_front: octet capture front end
// Counts payload octets, shifts header and address octets into place and
// hands a complete packet record on at the end-of-packet transaction.
// ----------------------------------------------------------------------------
module arpp_front
  import arpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       carries_byte,
  input  logic       last_item,
  output logic       rec_push,
  output pkt_rec_t   rec
);

  pkt_rec_t cur;
  pkt_rec_t cur_next;

  always_comb begin
    cur_next = cur;
    if (carries_byte) begin
      if (cur.count < OFS_PROTO) begin
        cur_next.hw_space = {cur.hw_space[7:0], data_byte};
      end else if (cur.count < OFS_HLEN) begin
        cur_next.proto_space = {cur.proto_space[7:0], data_byte};
      end else if (cur.count == OFS_HLEN) begin
        cur_next.hw_len = data_byte;
      end else if (cur.count == OFS_PLEN) begin
        cur_next.proto_len = data_byte;
      end else if (cur.count < OFS_SMAC) begin
        cur_next.opcode = {cur.opcode[7:0], data_byte};
      end else if (cur.count < OFS_SIP) begin
        cur_next.sender_mac = {cur.sender_mac[39:0], data_byte};
      end else if (cur.count < OFS_TMAC) begin
        cur_next.sender_ip = {cur.sender_ip[23:0], data_byte};
      end else if (cur.count < OFS_TIP) begin
        cur_next.target_mac = {cur.target_mac[39:0], data_byte};
      end else if (cur.count < OFS_END) begin
        cur_next.target_ip = {cur.target_ip[23:0], data_byte};
      end
      if (cur.count != COUNT_MAX) begin
        cur_next.count = cur.count + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (accept) begin
      if (last_item) begin
        cur <= '0;
      end else begin
        cur <= cur_next;
      end
    end
  end

  assign rec_push = accept && last_item;
  assign rec      = cur_next;

endmodule

// ===== rtl/core/arpp_queue.sv =====
// ----------------------------------------------------------------------------
// arpp_queue: two-entry packet record queue
// Decouples the capture front end from the checking back end.
// ----------------------------------------------------------------------------
module arpp_queue
  import arpp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  pkt_rec_t wr_data,
  input  logic     rd_en,
  output pkt_rec_t rd_data,
  output logic     q_full,
  output logic     q_empty
);

  pkt_rec_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);

endmodule

// ===== rtl/core/arpp_back.sv =====
// ----------------------------------------------------------------------------
// arpp_back: packet check back end
// Holds the address space registers, judges each packet record and keeps
// the result in an output register until it is popped.
// ----------------------------------------------------------------------------
module arpp_back
  import arpp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    q_empty,
  input  pkt_rec_t                q_rec,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [1:0]              status,
  output logic [15:0]             hw_space,
  output logic [15:0]             proto_space,
  output logic [7:0]              hw_length,
  output logic [7:0]              proto_length,
  output logic [15:0]             operation,
  output logic [47:0]             sender_mac,
  output logic [31:0]             sender_ip,
  output logic [47:0]             target_mac,
  output logic [31:0]             target_ip
);

  logic [15:0] exp_hw_space;
  logic [15:0] exp_proto_space;
  logic        out_valid;

  logic        hdr_ok;
  logic [8:0]  len_sum;
  logic [9:0]  addr_span;
  count_t      body_len;
  logic        len_bad;
  logic        spaces_bad;
  logic        op_bad;
  logic [1:0]  status_next;
  logic        is_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_hw_space    <= RST_HW_SPACE;
      exp_proto_space <= RST_PROTO_SPACE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HW_SPACE:    exp_hw_space    <= cfg_data;
        REG_PROTO_SPACE: exp_proto_space <= cfg_data;
        default:         exp_hw_space    <= exp_hw_space;
      endcase
    end
  end

  // Address block must fit: two hardware and two protocol addresses
  always_comb begin
    hdr_ok     = (q_rec.count >= HDR_BYTES);
    len_sum    = {1'b0, q_rec.hw_len} + {1'b0, q_rec.proto_len};
    addr_span  = {len_sum, 1'b0};
    body_len   = q_rec.count - HDR_BYTES;
    len_bad    = (body_len < COUNT_BITS'(addr_span));
    spaces_bad = (q_rec.hw_space != exp_hw_space) ||
                 (q_rec.proto_space != exp_proto_space) ||
                 (q_rec.hw_len != HW_LEN_OK) ||
                 (q_rec.proto_len != PROTO_LEN_OK);
    op_bad     = (q_rec.opcode != OP_REQUEST) && (q_rec.opcode != OP_REPLY);
    if (!hdr_ok || len_bad) begin
      status_next = ST_MALFORMED;
    end else if (spaces_bad) begin
      status_next = ST_SPACES;
    end else if (op_bad) begin
      status_next = ST_OPCODE;
    end else begin
      status_next = ST_OK;
    end
    is_ok = (status_next == ST_OK);
  end

  assign q_pop = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status       <= status_next;
      hw_space     <= hdr_ok ? q_rec.hw_space    : 16'd0;
      proto_space  <= hdr_ok ? q_rec.proto_space : 16'd0;
      hw_length    <= hdr_ok ? q_rec.hw_len      : 8'd0;
      proto_length <= hdr_ok ? q_rec.proto_len   : 8'd0;
      operation    <= hdr_ok ? q_rec.opcode      : 16'd0;
      sender_mac   <= is_ok  ? q_rec.sender_mac  : 48'd0;
      sender_ip    <= is_ok  ? q_rec.sender_ip   : 32'd0;
      target_mac   <= is_ok  ? q_rec.target_mac  : 48'd0;
      target_ip    <= is_ok  ? q_rec.target_ip   : 32'd0;
    end
  end

  assign empty = !out_valid;

endmodule
